// ===== rtl/usbep_pkg.sv =====
// ----------------------------------------------------------------------------
// usbep_pkg
// Shared types and constants for the endpoint-zero control transfer engine.
// ----------------------------------------------------------------------------
`default_nettype none

package usbep_pkg;

  localparam int NUM_ENDPOINTS_DEF = 12;
  localparam int BUFFER_BYTES_DEF  = 64;
  // number of endpoints the 4-bit index field can address
  localparam int MAX_ENDPOINTS     = 16;

  localparam logic [15:0] CFG_LEN_RESET  = 16'd9;
  localparam logic [15:0] DEV_DESC_LEN   = 16'd18;
  localparam logic [15:0] DESC_TYPE_MASK = 16'hff00;
  localparam logic [15:0] DESC_DEVICE    = 16'h0100;
  localparam logic [15:0] DESC_CONFIG    = 16'h0200;
  localparam logic [15:0] STATUS_LEN     = 16'd2;
  localparam logic [15:0] CONFIG_LEN     = 16'd1;
  localparam logic [15:0] IFACE_LEN      = 16'd1;
  localparam logic [15:0] SYNCH_LEN      = 16'd2;
  localparam logic [6:0]  SETUP_BYTES    = 7'd8;
  localparam logic [6:0]  ADDR_MASK      = 7'h7f;

  localparam logic [15:0] FEAT_HALT        = 16'd0;
  localparam logic [15:0] FEAT_REMOTE_WAKE = 16'd1;

  localparam logic [4:0] RCPT_DEVICE   = 5'd0;
  localparam logic [4:0] RCPT_ENDPOINT = 5'd2;

  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;
  localparam logic [7:0] REQ_SYNCH_FRAME       = 8'd12;

  typedef enum logic [1:0] {
    OP_SETUP      = 2'd0,
    OP_OUT        = 2'd1,
    OP_IN_DONE    = 2'd2,
    OP_LINK_RESET = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SRC_NONE    = 2'd0,
    SRC_DEV_ROM = 2'd1,
    SRC_CFG     = 2'd2,
    SRC_WORD    = 2'd3
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE         = 3'd0,
    ST_WAIT_IN      = 3'd1,
    ST_STAT_OUT     = 3'd2,
    ST_STAT_IN      = 3'd3,
    ST_ADDR_STAT_IN = 3'd4
  } stage_e;

  typedef struct packed {
    op_e         op;
    logic [4:0]  buffer_id;
    logic [6:0]  packet_size;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
  } item_t;

  typedef struct packed {
    logic        send;
    logic [4:0]  send_buffer;
    logic [15:0] send_length;
    src_e        send_source;
    logic [15:0] reply_word;
    logic        stall_res;
    logic        address_valid;
    logic [6:0]  device_address;
    logic        halt_write;
    logic [3:0]  halt_endpoint;
    logic        halt_value;
    logic        remote_wake_enabled;
  } result_t;

  // halt is zero-padded up to MAX_ENDPOINTS
  typedef struct packed {
    stage_e                   stage;
    logic [6:0]               pending_address;
    logic [7:0]               configuration_value;
    logic                     remote_wake;
    logic [MAX_ENDPOINTS-1:0] halt;
  } state_t;

  function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/usbep_decode.sv =====
// ----------------------------------------------------------------------------
// usbep_decode
// Single-pass event decode: builds one result and the next control state.
// ----------------------------------------------------------------------------
`default_nettype none

module usbep_decode import usbep_pkg::*; #(
  parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEF,
  parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF
) (
  input  item_t       item_i,
  input  state_t      st_i,
  input  logic [15:0] cfg_len_i,
  output result_t     res_o,
  output state_t      st_o
);

  logic [6:0]  size;
  logic [3:0]  ep;
  logic        ep_ok;
  logic        is_setup;
  logic        stall;
  logic        setup_err;
  logic        feat_val;
  logic [15:0] wlen;
  logic [15:0] desc_type;

  always_comb begin
    size = (item_i.packet_size > 7'(BUFFER_BYTES)) ? 7'(BUFFER_BYTES) : item_i.packet_size;
    ep        = item_i.request_index[3:0];
    ep_ok     = {1'b0, ep} < 5'(NUM_ENDPOINTS);
    is_setup  = (item_i.op == OP_SETUP);
    wlen      = item_i.request_length;
    desc_type = item_i.request_value & DESC_TYPE_MASK;
    feat_val  = (item_i.request_code == REQ_SET_FEATURE);
  end

  always_comb begin
    res_o     = '0;
    st_o      = st_i;
    stall     = 1'b0;
    setup_err = 1'b0;
    case (item_i.op)
      OP_SETUP, OP_OUT: begin
        if (st_i.stage == ST_IDLE) begin
          if (is_setup && size == SETUP_BYTES) begin
            res_o.send        = 1'b1;
            res_o.send_buffer = item_i.buffer_id;
            case (item_i.request_code)
              REQ_GET_DESCRIPTOR: begin
                if (desc_type == DESC_DEVICE) begin
                  res_o.send_length = min16(DEV_DESC_LEN, wlen);
                  res_o.send_source = SRC_DEV_ROM;
                  st_o.stage        = ST_WAIT_IN;
                end else if (desc_type == DESC_CONFIG) begin
                  res_o.send_length = min16(cfg_len_i, wlen);
                  res_o.send_source = SRC_CFG;
                  st_o.stage        = ST_WAIT_IN;
                end else begin
                  setup_err = 1'b1;
                end
              end
              REQ_SET_ADDRESS: begin
                st_o.pending_address = item_i.request_value[6:0] & ADDR_MASK;
                st_o.stage           = ST_ADDR_STAT_IN;
              end
              REQ_SET_CONFIGURATION: begin
                st_o.configuration_value = item_i.request_value[7:0];
                st_o.stage               = ST_STAT_IN;
              end
              REQ_GET_CONFIGURATION: begin
                res_o.send_length = min16(CONFIG_LEN, wlen);
                res_o.send_source = SRC_WORD;
                res_o.reply_word  = {8'h00, st_i.configuration_value};
                st_o.stage        = ST_WAIT_IN;
              end
              REQ_SET_FEATURE, REQ_CLEAR_FEATURE: begin
                if (item_i.request_value == FEAT_HALT) begin
                  if (ep_ok) begin
                    st_o.halt[ep]       = feat_val;
                    res_o.halt_write    = 1'b1;
                    res_o.halt_endpoint = ep;
                    res_o.halt_value    = feat_val;
                  end
                end else if (item_i.request_value == FEAT_REMOTE_WAKE) begin
                  st_o.remote_wake = feat_val;
                end
                st_o.stage = ST_STAT_IN;
              end
              REQ_GET_STATUS: begin
                res_o.send_length = min16(STATUS_LEN, wlen);
                res_o.send_source = SRC_WORD;
                if (item_i.request_type[4:0] == RCPT_DEVICE) begin
                  res_o.reply_word = {14'd0, st_i.remote_wake, 1'b1};
                end else if (item_i.request_type[4:0] == RCPT_ENDPOINT) begin
                  res_o.reply_word = {15'd0, st_i.halt[ep]};
                end
                st_o.stage = ST_WAIT_IN;
              end
              REQ_SET_INTERFACE: begin
                st_o.stage = ST_STAT_IN;
              end
              REQ_GET_INTERFACE: begin
                res_o.send_length = min16(IFACE_LEN, wlen);
                res_o.send_source = SRC_WORD;
                st_o.stage        = ST_WAIT_IN;
              end
              REQ_SYNCH_FRAME: begin
                res_o.send_length = min16(SYNCH_LEN, wlen);
                res_o.send_source = SRC_WORD;
                st_o.stage        = ST_WAIT_IN;
              end
              default: begin
                setup_err = 1'b1;
              end
            endcase
            stall = setup_err;
          end else begin
            stall = 1'b1;
          end
        end else if (st_i.stage == ST_STAT_OUT && !is_setup && size == 7'd0) begin
          st_o.stage = ST_IDLE;
        end else begin
          stall = 1'b1;
        end
        // drop whatever was decoded, release the buffer and stall
        if (stall) begin
          res_o             = '0;
          st_o              = st_i;
          res_o.send_buffer = item_i.buffer_id;
          res_o.stall_res   = 1'b1;
          st_o.stage        = ST_IDLE;
        end
      end
      OP_IN_DONE: begin
        case (st_i.stage)
          ST_ADDR_STAT_IN: begin
            res_o.address_valid  = 1'b1;
            res_o.device_address = st_i.pending_address;
            st_o.stage           = ST_IDLE;
          end
          ST_STAT_IN: st_o.stage = ST_IDLE;
          ST_WAIT_IN: st_o.stage = ST_STAT_OUT;
          default:    st_o.stage = st_i.stage;
        endcase
      end
      default: begin
        st_o.stage = ST_IDLE;
      end
    endcase
    res_o.remote_wake_enabled = st_o.remote_wake;
  end

endmodule

`default_nettype wire

// ===== rtl/usbep_state.sv =====
// ----------------------------------------------------------------------------
// usbep_state
// Control state registers: stage, pending address, configuration value,
// remote wake enable and per-endpoint halt bits.
// ----------------------------------------------------------------------------
`default_nettype none

module usbep_state import usbep_pkg::*; #(
  parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   upd_i,
  input  state_t st_d_i,
  output state_t st_o
);

  stage_e                   stage_q;
  logic [6:0]               pending_address_q;
  logic [7:0]               configuration_value_q;
  logic                     remote_wake_q;
  logic [NUM_ENDPOINTS-1:0] halt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q               <= ST_IDLE;
      pending_address_q     <= '0;
      configuration_value_q <= '0;
      remote_wake_q         <= 1'b0;
      halt_q                <= '0;
    end else if (upd_i) begin
      stage_q               <= st_d_i.stage;
      pending_address_q     <= st_d_i.pending_address;
      configuration_value_q <= st_d_i.configuration_value;
      remote_wake_q         <= st_d_i.remote_wake;
      halt_q                <= st_d_i.halt[NUM_ENDPOINTS-1:0];
    end
  end

  always_comb begin
    st_o.stage               = stage_q;
    st_o.pending_address     = pending_address_q;
    st_o.configuration_value = configuration_value_q;
    st_o.remote_wake         = remote_wake_q;
    st_o.halt                = MAX_ENDPOINTS'(halt_q);
  end

endmodule

`default_nettype wire

// ===== rtl/usb_control_endpoint_fsm_core.sv =====
// ----------------------------------------------------------------------------
// usb_control_endpoint_fsm_core
// Endpoint-zero control transfer engine for standard USB requests.
// ----------------------------------------------------------------------------
// Each event transaction yields exactly one result transaction. An accepted
// event lands in an input register, is decoded in one pass against the
// control state and written to the result register, where out_valid_o
// rises and the result waits until it is taken; one event per cycle is
// sustained while the result side keeps taking transactions.
// Throughput is set by the input and result registers; the input register
// lets a new event be taken while a finished result still waits. The
// configuration descriptor length register is written through its own
// channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_control_endpoint_fsm_core import usbep_pkg::*; #(
  parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEF,
  parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [4:0]  buffer_id_i,
  input  logic [6:0]  packet_size_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_value_i,
  input  logic [15:0] request_index_i,
  input  logic [15:0] request_length_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        send_o,
  output logic [4:0]  send_buffer_o,
  output logic [15:0] send_length_o,
  output logic [1:0]  send_source_o,
  output logic [15:0] reply_word_o,
  output logic        stall_res_o,
  output logic        address_valid_o,
  output logic [6:0]  device_address_o,
  output logic        halt_write_o,
  output logic [3:0]  halt_endpoint_o,
  output logic        halt_value_o,
  output logic        remote_wake_enabled_o
);

  logic [15:0] cfg_len_q;
  logic        in_valid_q, in_valid_d;
  item_t       in_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_q;
  logic        advance;
  logic        in_accept;
  result_t     res_d;
  state_t      st_q;
  state_t      st_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= CFG_LEN_RESET;
    end else if (cfg_valid_i) begin
      cfg_len_q <= cfg_data_i;
    end
  end

  // advance the decode stage whenever an event is held and the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q.op             <= op_e'(op_i);
      in_q.buffer_id      <= buffer_id_i;
      in_q.packet_size    <= packet_size_i;
      in_q.request_type   <= request_type_i;
      in_q.request_code   <= request_code_i;
      in_q.request_value  <= request_value_i;
      in_q.request_index  <= request_index_i;
      in_q.request_length <= request_length_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  usbep_decode #(
    .NUM_ENDPOINTS (NUM_ENDPOINTS),
    .BUFFER_BYTES  (BUFFER_BYTES)
  ) u_decode (
    .item_i    (in_q),
    .st_i      (st_q),
    .cfg_len_i (cfg_len_q),
    .res_o     (res_d),
    .st_o      (st_d)
  );

  usbep_state #(
    .NUM_ENDPOINTS (NUM_ENDPOINTS)
  ) u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (advance),
    .st_d_i (st_d),
    .st_o   (st_q)
  );

  assign out_valid_o           = out_valid_q;
  assign send_o                = out_q.send;
  assign send_buffer_o         = out_q.send_buffer;
  assign send_length_o         = out_q.send_length;
  assign send_source_o         = out_q.send_source;
  assign reply_word_o          = out_q.reply_word;
  assign stall_res_o           = out_q.stall_res;
  assign address_valid_o       = out_q.address_valid;
  assign device_address_o      = out_q.device_address;
  assign halt_write_o          = out_q.halt_write;
  assign halt_endpoint_o       = out_q.halt_endpoint;
  assign halt_value_o          = out_q.halt_value;
  assign remote_wake_enabled_o = out_q.remote_wake_enabled;

  a_stall_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(send_o && stall_res_o))
    else $error("stall result also queues a reply");

  a_addr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && address_valid_o |-> !send_o && !stall_res_o)
    else $error("address update combined with a packet");

  a_halt_acked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halt_write_o |-> send_o)
    else $error("halt write without status reply");

  a_stall_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.stall_res |=> st_q.stage == ST_IDLE)
    else $error("stage not idle after a stall");

  a_halt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.halt_write |-> {1'b0, res_d.halt_endpoint} < 5'(NUM_ENDPOINTS))
    else $error("halt write to a missing endpoint");

endmodule

`default_nettype wire
